>>> src/lpizt_pkg.sv
package lpizt_pkg;

  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth = 4;

  typedef enum logic [3:0] {
    CMD_WRITE     = 4'd0,
    CMD_STATUS    = 4'd1,
    CMD_START     = 4'd2,
    CMD_CLR_CTL   = 4'd3,
    CMD_CTL_RESET = 4'd4,
    CMD_CLR_FLAG  = 4'd5,
    CMD_SET_FBUF  = 4'd6,
    CMD_EN_FLAG   = 4'd7,
    CMD_IACK      = 4'd8,
    CMD_PRESET    = 4'd9,
    CMD_TICK      = 4'd10,
    CMD_PAPER     = 4'd11
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DIAG  = 2'd0,
    REG_CHAR  = 2'd1,
    REG_ZONE  = 2'd2,
    REG_SLEW  = 2'd3
  } reg_e;

  localparam logic [6:0] ChCr = 7'd13;
  localparam logic [6:0] ChLf = 7'd10;
  localparam logic [6:0] ChFf = 7'd12;
  localparam logic [6:0] ChBlank = 7'd32;
  localparam logic [6:0] PageCols = 7'd80;
  localparam logic [5:0] PageLines = 6'd60;
  localparam logic [6:0] FormLines = 7'd66;
  localparam logic [15:0] StBusy = 16'o000001;
  localparam logic [15:0] StNrdy = 16'o100000;

  typedef struct packed {
    logic [2:0]  n;
    logic [6:0]  c0;
    logic [6:0]  c1;
    logic [6:0]  c2;
    logic [15:0] status;
    logic        flag;
    logic        irq;
    logic        busy;
  } step_t;

endpackage

>>> src/lpizt_front.sv
module lpizt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               valid_i,
  input  logic [3:0]         cmd_i,
  input  logic [15:0]        data_in_i,
  input  logic               paper_i,
  input  logic               online_i,
  input  logic               power_i,
  output lpizt_pkg::step_t   step_o
);
  import lpizt_pkg::*;

  logic        diag_q;
  logic [23:0] char_q, zone_q, slew_q;
  logic [15:0] ow_q, ow_d, st_q, st_d;
  logic        ctl_q, ctl_d, flg_q, flg_d, fb_q, fb_d, pend_q, pend_d;
  logic [6:0]  col_q, col_d;
  logic [5:0]  line_q, line_d;
  logic [31:0] dl_q, dl_d, wait_v, dl_dec;
  logic [6:0]  c, cmod, lnext, zm;
  logic        ctlch, zero_mod;
  logic [5:0]  lf_line;
  logic [31:0] slew_mul;
  logic [2:0]  n;
  logic [6:0]  o0, o1, o2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_q <= 1'b0;
      char_q <= 24'd2;
      zone_q <= 24'd55300;
      slew_q <= 24'd17380;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_DIAG: diag_q <= cfg_data_i[0];
        REG_CHAR: char_q <= cfg_data_i;
        REG_ZONE: zone_q <= cfg_data_i;
        REG_SLEW: slew_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ow_d = ow_q; st_d = st_q; ctl_d = ctl_q; flg_d = flg_q; fb_d = fb_q;
    pend_d = pend_q; col_d = col_q; line_d = line_q; dl_d = dl_q;
    n = 3'd1; o0 = '0; o1 = '0; o2 = '0;
    ctlch = (ow_q == {9'd0, ChFf}) || (ow_q == {9'd0, ChLf}) || (ow_q == {9'd0, ChCr});
    cmod = (col_q < 7'd127) ? col_q + 7'd1 : col_q;
    zm = ctlch ? col_q : cmod;
    zero_mod = (zm == 7'd0) || (zm == 7'd20) || (zm == 7'd40) || (zm == 7'd60) ||
               (zm == 7'd80) || (zm == 7'd100) || (zm == 7'd120);
    lf_line = (line_q + 6'd1 == PageLines) ? 6'd0 : line_q + 6'd1;
    slew_mul = 32'd0;
    lnext = 7'd0;
    wait_v = 32'd0;
    c = ow_q[6:0];
    dl_dec = (dl_q != 32'd0) ? dl_q - 32'd1 : dl_q;
    if (!ctlch) begin
      wait_v = {8'd0, zero_mod ? zone_q : char_q};
    end else begin
      wait_v = {8'd0, zero_mod ? char_q : zone_q};
      if (ow_q[6:0] == ChLf) begin
        lnext = (lf_line == 6'd0) ? (FormLines - {1'b0, PageLines}) : 7'd1;
      end else if (ow_q[6:0] == ChFf) begin
        lnext = FormLines - {1'b0, line_q};
      end
      slew_mul = 32'({8'd0, slew_q} * {25'd0, lnext});
    end
    case (cmd_e'(cmd_i))
      CMD_WRITE: ow_d = data_in_i;
      CMD_STATUS: if (!diag_q) begin
        if (power_i) st_d = (!paper_i || !online_i || pend_q) ? StBusy : 16'd0;
        else st_d = StBusy | StNrdy;
      end
      CMD_START: begin
        ctl_d = 1'b1;
        if (diag_q) begin
          st_d = ow_q; pend_d = 1'b1; dl_d = 32'd1;
        end else begin
          if (!ctlch) col_d = cmod;
          else begin
            col_d = 7'd0;
            if (ow_q[6:0] == ChLf && ow_q[15:7] == 9'd0) line_d = lf_line;
            else if (ow_q[6:0] == ChFf && ow_q[15:7] == 9'd0) line_d = 6'd0;
          end
          if (!pend_q) begin
            pend_d = 1'b1;
            dl_d = wait_v + slew_mul;
          end
        end
      end
      CMD_CLR_CTL: ctl_d = 1'b0;
      CMD_CTL_RESET: begin ctl_d = 1'b0; pend_d = 1'b0; dl_d = 32'd0; end
      CMD_CLR_FLAG: begin fb_d = 1'b0; flg_d = 1'b0; end
      CMD_SET_FBUF: fb_d = 1'b1;
      CMD_EN_FLAG: if (fb_q) flg_d = 1'b1;
      CMD_IACK: fb_d = 1'b0;
      CMD_PRESET: begin fb_d = 1'b1; ow_d = 16'd0; end
      CMD_TICK: if (pend_q) begin
        dl_d = dl_dec;
        if (dl_dec == 32'd0) begin
          if (diag_q) begin
            pend_d = 1'b0; fb_d = 1'b1; flg_d = 1'b1;
          end else if (paper_i && online_i && power_i) begin
            pend_d = 1'b0; fb_d = 1'b1; flg_d = 1'b1;
            if ((c < 7'd32 || c > 7'd95) && c != ChFf && c != ChLf && c != ChCr)
              c = ChBlank;
            n = 3'd0;
            if (col_q > PageCols) begin
              o0 = ChCr; n = 3'd1; col_d = 7'd1;
            end
            if (n == 3'd0) o0 = c; else o1 = c;
            n = n + 3'd1;
            if (line_q == 6'd0 && c == ChLf) begin
              if (n == 3'd1) o1 = ChFf; else o2 = ChFf;
              n = n + 3'd1;
            end
            n = n + 3'd4;
          end
        end
      end
      CMD_PAPER: begin col_d = 7'd0; line_d = 6'd0; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q <= '0; st_q <= '0; ctl_q <= 1'b0; flg_q <= 1'b0; fb_q <= 1'b0;
      pend_q <= 1'b0; col_q <= '0; line_q <= '0; dl_q <= '0;
    end else if (valid_i) begin
      ow_q <= ow_d; st_q <= st_d; ctl_q <= ctl_d; flg_q <= flg_d; fb_q <= fb_d;
      pend_q <= pend_d; col_q <= col_d; line_q <= line_d; dl_q <= dl_d;
    end
  end

  assign step_o.n = n;
  assign step_o.c0 = o0;
  assign step_o.c1 = o1;
  assign step_o.c2 = o2;
  assign step_o.status = st_d;
  assign step_o.flag = flg_d;
  assign step_o.irq = ctl_d & flg_d & fb_d;
  assign step_o.busy = pend_d;

endmodule

>>> src/lpizt_back.sv
module lpizt_back #(
  parameter int unsigned Depth = lpizt_pkg::QDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpizt_pkg::step_t step_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             print_valid_o,
  output logic [6:0]       print_char_o,
  output logic [15:0]      status_word_o,
  output logic             flag_out_o,
  output logic             irq_request_o,
  output logic             busy_out_o,
  output logic             last_o
);
  import lpizt_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  step_t          mem_q [Depth];
  logic [AW-1:0]  wr_q, rd_q;
  logic [AW:0]    cnt_q;
  logic [1:0]     sub_q;
  step_t          head;
  logic           pv, lst, do_pop, do_push;
  logic [2:0]     cnt_items;

  assign head = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == (AW+1)'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign pv = head.n[2];
  assign cnt_items = pv ? {1'b0, head.n[1:0]} : 3'd1;
  assign lst = ({1'b0, sub_q} + 3'd1) == cnt_items;

  always_comb begin
    case (sub_q)
      2'd0: print_char_o = pv ? head.c0 : 7'd0;
      2'd1: print_char_o = head.c1;
      default: print_char_o = head.c2;
    endcase
  end

  assign print_valid_o = pv;
  assign status_word_o = head.status;
  assign flag_out_o = head.flag;
  assign irq_request_o = head.irq;
  assign busy_out_o = head.busy;
  assign last_o = lst;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop) begin
        if (lst) begin
          sub_q <= '0;
          rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop && lst);
    end
  end

endmodule

>>> src/line_printer_interface_zone_timing.sv
// Line printer interface with zone timing. Push one command beat per cycle while full
// is low; each beat yields one to three result beats (a CR before a character past
// column 80, an FF after an LF at top of form), marked by last. The front updates
// the printer state for each accepted beat; a four-entry queue feeds the back, which pops
// one result beat per cycle while pop is high, so a beat with several results holds
// the head until last. Configuration writes take effect on the next edge.
module line_printer_interface_zone_timing #(
  parameter int unsigned QueueDepth = lpizt_pkg::QDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  cmd_i,
  input  logic [15:0] data_in_i,
  input  logic        paper_loaded_i,
  input  logic        printer_online_i,
  input  logic        power_on_i,
  output logic        empty,
  input  logic        pop,
  output logic        print_valid_o,
  output logic [6:0]  print_char_o,
  output logic [15:0] status_word_o,
  output logic        flag_out_o,
  output logic        irq_request_o,
  output logic        busy_out_o,
  output logic        last_o
);
  import lpizt_pkg::*;

  step_t step;
  logic  acc;

  assign acc = push && !full;

  lpizt_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .valid_i(acc), .cmd_i, .data_in_i,
    .paper_i(paper_loaded_i), .online_i(printer_online_i), .power_i(power_on_i),
    .step_o(step)
  );

  lpizt_back #(.Depth(QueueDepth)) u_back (
    .clk_i, .rst_ni, .push_i(push), .step_i(step), .full_o(full),
    .pop_i(pop), .empty_o(empty),
    .print_valid_o, .print_char_o, .status_word_o, .flag_out_o,
    .irq_request_o, .busy_out_o, .last_o
  );

endmodule
